// ===== hw/rtl/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the sensor frame decoder.
package htfd_pkg;

    localparam int unsigned CfgIndexWidth = 2;
    localparam logic [CfgIndexWidth-1:0] REG_CRC_POLYNOMIAL = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_CRC_INITIAL    = 2'd1;

    localparam logic [7:0] CRC_POLYNOMIAL_RESET = 8'h31;
    localparam logic [7:0] CRC_INITIAL_RESET    = 8'hFF;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd12500;
    localparam logic [14:0] HUM_OFFSET  = 15'd600;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [29:0] HEATER_PRODUCT_LIMIT = 30'd727438500;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } t_frame_status;

    typedef struct packed {
        logic [7:0] polynomial;
        logic [7:0] initial_value;
    } t_crc_cfg;

    typedef struct packed {
        logic temp_ok;
        logic hum_ok;
    } t_crc_flags;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] poly);
        logic [7:0] crc;
        crc = crc_in;
        for (int k = 0; k < 8; k++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ poly;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/htfd_crc_check.sv =====
// Two-stage CRC-8 check of the temperature and humidity byte pairs.
module htfd_crc_check
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_crc_cfg   i_cfg,
    input  logic [7:0] i_temp_msb,
    input  logic [7:0] i_temp_lsb,
    input  logic [7:0] i_temp_check,
    input  logic [7:0] i_hum_msb,
    input  logic [7:0] i_hum_lsb,
    input  logic [7:0] i_hum_check,
    output t_crc_flags o_flags
);

    logic [7:0] r_temp_crc;
    logic [7:0] r_hum_crc;
    logic [7:0] r_temp_lsb;
    logic [7:0] r_hum_lsb;
    logic [7:0] r_temp_check;
    logic [7:0] r_hum_check;
    t_crc_flags r_flags;

    logic [7:0] n_temp_crc;
    logic [7:0] n_hum_crc;
    t_crc_flags n_flags;

    always_comb begin
        n_temp_crc = crc8_byte(i_cfg.initial_value ^ i_temp_msb, i_cfg.polynomial);
        n_hum_crc  = crc8_byte(i_cfg.initial_value ^ i_hum_msb, i_cfg.polynomial);
        n_flags.temp_ok = (crc8_byte(r_temp_crc ^ r_temp_lsb, i_cfg.polynomial) == r_temp_check);
        n_flags.hum_ok  = (crc8_byte(r_hum_crc ^ r_hum_lsb, i_cfg.polynomial) == r_hum_check);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_temp_crc   <= n_temp_crc;
            r_hum_crc    <= n_hum_crc;
            r_temp_lsb   <= i_temp_lsb;
            r_hum_lsb    <= i_hum_lsb;
            r_temp_check <= i_temp_check;
            r_hum_check  <= i_hum_check;
            r_flags      <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/htfd_scale.sv =====
// Two-stage conversion of the raw words to hundredths, with the heater threshold test.
module htfd_scale
    import htfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_temp_raw,
    input  logic [15:0]        i_hum_raw,
    output logic signed [14:0] o_temperature_centi,
    output logic signed [14:0] o_humidity_centi,
    output logic               o_heater
);

    logic [30:0] r_temp_prod;
    logic [29:0] r_hum_prod;
    logic signed [14:0] r_temperature_centi;
    logic signed [14:0] r_humidity_centi;
    logic r_heater;

    logic [30:0] n_temp_prod;
    logic [29:0] n_hum_prod;
    logic [16:0] temp_rem;
    logic [16:0] hum_rem;
    logic [14:0] temp_quot;
    logic [13:0] hum_quot;
    logic signed [14:0] n_temperature_centi;
    logic signed [14:0] n_humidity_centi;
    logic n_heater;

    // The quotient by 65535 is the upper half plus one when the folded remainder reaches 65535.
    always_comb begin
        n_temp_prod = 31'(TEMP_SPAN) * 31'(i_temp_raw);
        n_hum_prod  = 30'(HUM_SPAN) * 30'(i_hum_raw);
        temp_rem  = 17'(r_temp_prod[15:0]) + 17'(r_temp_prod[30:16]);
        hum_rem   = 17'(r_hum_prod[15:0]) + 17'(r_hum_prod[29:16]);
        temp_quot = r_temp_prod[30:16] + 15'(temp_rem >= 17'(FULL_SCALE));
        hum_quot  = r_hum_prod[29:16] + 14'(hum_rem >= 17'(FULL_SCALE));
        n_temperature_centi = $signed(temp_quot - TEMP_OFFSET);
        n_humidity_centi    = $signed(15'(hum_quot) - HUM_OFFSET);
        n_heater = (r_hum_prod > HEATER_PRODUCT_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_temp_prod         <= n_temp_prod;
            r_hum_prod          <= n_hum_prod;
            r_temperature_centi <= n_temperature_centi;
            r_humidity_centi    <= n_humidity_centi;
            r_heater            <= n_heater;
        end
    end

    assign o_temperature_centi = r_temperature_centi;
    assign o_humidity_centi    = r_humidity_centi;
    assign o_heater            = r_heater;

endmodule

// ===== hw/rtl/humidity_temperature_frame_decode_top.sv =====
// Top level of the CRC-8 checked humidity and temperature sensor frame decoder.
// One six-byte frame is accepted per transaction and gives exactly one result transaction;
// a new frame can be taken in every cycle in which the three pipeline stages (first CRC byte
// and multiplication, second CRC byte and division by full scale, result selection) advance;
// they advance together whenever the output register is empty or being taken. A frame
// with a bad temperature CRC reports status 1, otherwise a bad humidity CRC reports status 2,
// and in both cases the values and the heater request are zero. The CRC registers must only be
// written while no transaction is in flight.
module humidity_temperature_frame_decode_top
    import htfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [7:0]               i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_temp_msb,
    input  logic [7:0]               i_temp_lsb,
    input  logic [7:0]               i_temp_check,
    input  logic [7:0]               i_hum_msb,
    input  logic [7:0]               i_hum_lsb,
    input  logic [7:0]               i_hum_check,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_frame_status,
    output logic signed [14:0]       o_temperature_centi,
    output logic signed [14:0]       o_humidity_centi,
    output logic                     o_heater_request
);

    t_crc_cfg r_cfg;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    t_frame_status r_status;
    logic signed [14:0] r_temperature_centi;
    logic signed [14:0] r_humidity_centi;
    logic r_heater;

    t_frame_status n_status;
    logic signed [14:0] n_temperature_centi;
    logic signed [14:0] n_humidity_centi;
    logic n_heater;

    logic advance;
    t_crc_flags flags;
    logic signed [14:0] scaled_temp;
    logic signed [14:0] scaled_hum;
    logic scaled_heater;

    assign advance = !r_v3 || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial    <= CRC_POLYNOMIAL_RESET;
            r_cfg.initial_value <= CRC_INITIAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CRC_POLYNOMIAL: r_cfg.polynomial    <= i_cfg_data;
                REG_CRC_INITIAL:    r_cfg.initial_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    htfd_crc_check u_crc_check (
        .i_clk        (i_clk),
        .i_en         (advance),
        .i_cfg        (r_cfg),
        .i_temp_msb   (i_temp_msb),
        .i_temp_lsb   (i_temp_lsb),
        .i_temp_check (i_temp_check),
        .i_hum_msb    (i_hum_msb),
        .i_hum_lsb    (i_hum_lsb),
        .i_hum_check  (i_hum_check),
        .o_flags      (flags)
    );

    htfd_scale u_scale (
        .i_clk               (i_clk),
        .i_en                (advance),
        .i_temp_raw          ({i_temp_msb, i_temp_lsb}),
        .i_hum_raw           ({i_hum_msb, i_hum_lsb}),
        .o_temperature_centi (scaled_temp),
        .o_humidity_centi    (scaled_hum),
        .o_heater            (scaled_heater)
    );

    always_comb begin
        n_status            = STATUS_OK;
        n_temperature_centi = scaled_temp;
        n_humidity_centi    = scaled_hum;
        n_heater            = scaled_heater;
        if (!flags.temp_ok || !flags.hum_ok) begin
            n_status            = flags.temp_ok ? STATUS_HUM_CRC : STATUS_TEMP_CRC;
            n_temperature_centi = '0;
            n_humidity_centi    = '0;
            n_heater            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status            <= n_status;
            r_temperature_centi <= n_temperature_centi;
            r_humidity_centi    <= n_humidity_centi;
            r_heater            <= n_heater;
        end
    end

    assign o_in_ready          = advance;
    assign o_out_valid         = r_v3;
    assign o_frame_status      = r_status;
    assign o_temperature_centi = r_temperature_centi;
    assign o_humidity_centi    = r_humidity_centi;
    assign o_heater_request    = r_heater;

    // A failed frame carries no measurement and no heater request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_status != STATUS_OK) |->
            (o_temperature_centi == '0) && (o_humidity_centi == '0) && !o_heater_request)
        else $error("Failed frame carries non-zero result fields.");

    // The heater threshold lies at 105.00 percent, so the truncated humidity cannot be below it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_heater_request |-> (o_humidity_centi >= 15'sd10500))
        else $error("Heater request raised below the humidity threshold.");

    // An accepted transaction always occupies the first stage in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v1)
        else $error("Accepted transaction lost at the first stage.");

    // While the output is stalled, every occupied stage keeps its transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_out_ready |=> r_v3 && (r_v2 == $past(r_v2)) && (r_v1 == $past(r_v1)))
        else $error("Pipeline stage changed during a stall.");

endmodule
